// ----- rtl/core/lci_pkg.sv -----
// Shared widths, status codes and pipeline side-band types for the line/cylinder solver.
// Depends on nothing; every other file in rtl/core depends on it.
`timescale 1ns / 1ps

package lci_pkg;

   // Fraction bits of the fixed-point inputs and of the returned path parameter.
   localparam int FRAC_BITS = 16;

   // Field widths.
   localparam int XW  = 32;              // origin coordinates, signed
   localparam int CW  = 18;              // direction cosines, signed
   localparam int RW  = 31;              // cylinder radius, unsigned
   localparam int TW  = 32;              // path parameter, unsigned

   // Internal widths.
   localparam int AW      = 2 * CW;      // a = c1^2 + c2^2
   localparam int BW      = XW + CW + 1; // b = x*c1 + y*c2, signed
   localparam int BMW     = BW - 1;      // |b|
   localparam int P2W     = 2 * XW;      // x^2 + y^2
   localparam int DW      = 100;         // discriminant, even width for the root
   localparam int SQW     = DW / 2;      // integer square root
   localparam int SQ_REMW = SQW + 3;     // root remainder
   localparam int NW      = SQW + 2;     // root numerator, non-negative
   localparam int QW      = TW;          // quotient bits
   localparam int QSHIFT  = QW - FRAC_BITS;
   localparam int CMPW    = (AW + QSHIFT > NW) ? AW + QSHIFT : NW;

   // Result status codes.
   localparam logic [1:0] ST_LARGER   = 2'd0;
   localparam logic [1:0] ST_SMALLER  = 2'd1;
   localparam logic [1:0] ST_NO_ROOT  = 2'd2;
   localparam logic [1:0] ST_ZERO_DIR = 2'd3;

   // Side-band carried alongside the square root.
   typedef struct packed {
      logic [AW-1:0]        a;
      logic signed [BW-1:0] b;
      logic [1:0]           status;
   } lci_sq_side_type;

   // Side-band carried alongside the divider.
   typedef struct packed {
      logic [1:0] status;
      logic       sat;
   } lci_div_side_type;

endpackage

// ----- rtl/core/lci_ifs.sv -----
// Valid/ready channel interfaces for the request, response and register-write ports.
// Depends on lci_pkg for the field widths.
`timescale 1ns / 1ps

interface lci_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [lci_pkg::XW-1:0]    origin_x;
   logic signed [lci_pkg::XW-1:0]    origin_y;
   logic signed [lci_pkg::CW-1:0]    dir_x;
   logic signed [lci_pkg::CW-1:0]    dir_y;

   modport source (output valid, origin_x, origin_y, dir_x, dir_y, input ready);
   modport sink   (input valid, origin_x, origin_y, dir_x, dir_y, output ready);
endinterface

interface lci_rsp_if;
   logic                    valid;
   logic                    ready;
   logic [lci_pkg::TW-1:0]  path_param;
   logic [1:0]              hit_status;

   modport source (output valid, path_param, hit_status, input ready);
   modport sink   (input valid, path_param, hit_status, output ready);
endinterface

interface lci_csr_if;
   logic                    valid;
   logic                    ready;
   logic [lci_pkg::RW-1:0]  cylinder_radius;

   modport source (output valid, cylinder_radius, input ready);
   modport sink   (input valid, cylinder_radius, output ready);
endinterface

// ----- rtl/core/lci_sqrt.sv -----
// Pipelined floor integer square root, one result bit per register stage.
// Depends on lci_pkg; carries the solver side-band alongside the root.
`timescale 1ns / 1ps

module lci_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  logic [lci_pkg::DW-1:0]    radicand,
   input  lci_pkg::lci_sq_side_type  side_in,
   output logic                      out_valid,
   output logic [lci_pkg::SQW-1:0]   root,
   output lci_pkg::lci_sq_side_type  side_out
);
   import lci_pkg::*;

   logic                 valid_ff [SQW];
   logic [SQ_REMW-1:0]   rem_ff   [SQW];
   logic [SQW-1:0]       root_ff  [SQW];
   logic [DW-1:0]        rad_ff   [SQW];
   lci_sq_side_type      side_ff  [SQW];

   genvar k;
   for (k = 0; k < SQW; k++) begin : g_step
      logic               p_valid;
      logic [SQ_REMW-1:0] p_rem;
      logic [SQW-1:0]     p_root;
      logic [DW-1:0]      p_rad;
      lci_sq_side_type    p_side;
      logic [SQ_REMW-1:0] trial_rem;
      logic [SQ_REMW-1:0] trial;
      logic [SQ_REMW-1:0] rem_in;
      logic [SQW-1:0]     root_in;
      logic               fits;

      // The first step starts from the radicand; later steps from the stage before.
      if (k == 0) begin : g_first
         assign p_valid = in_valid;
         assign p_rem   = '0;
         assign p_root  = '0;
         assign p_rad   = radicand;
         assign p_side  = side_in;
      end else begin : g_next
         assign p_valid = valid_ff[k-1];
         assign p_rem   = rem_ff[k-1];
         assign p_root  = root_ff[k-1];
         assign p_rad   = rad_ff[k-1];
         assign p_side  = side_ff[k-1];
      end

      // Bring down two radicand bits and try to set the next root bit.
      always_comb begin
         trial_rem = {p_rem[SQ_REMW-3:0], p_rad[DW-1 -: 2]};
         trial     = {1'b0, p_root, 2'b01};
         fits      = trial_rem >= trial;
         rem_in    = fits ? trial_rem - trial : trial_rem;
         root_in   = {p_root[SQW-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= p_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= p_rad << 2;
            side_ff[k] <= p_side;
         end
      end
   end

   assign out_valid = valid_ff[SQW-1];
   assign root      = root_ff[SQW-1];
   assign side_out  = side_ff[SQW-1];

endmodule

// ----- rtl/core/lci_div.sv -----
// Pipelined restoring divider giving the Q16.16 path parameter, one quotient bit per stage.
// Depends on lci_pkg; the numerator must be below the divisor shifted by the integer width.
`timescale 1ns / 1ps

module lci_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  logic [lci_pkg::NW-1:0]     num,
   input  logic [lci_pkg::AW-1:0]     den,
   input  lci_pkg::lci_div_side_type  side_in,
   output logic                       out_valid,
   output logic [lci_pkg::QW-1:0]     quot,
   output lci_pkg::lci_div_side_type  side_out
);
   import lci_pkg::*;

   logic              valid_ff [QW];
   logic [AW-1:0]     rem_ff   [QW];
   logic [QW-1:0]     low_ff   [QW];
   logic [QW-1:0]     q_ff     [QW];
   logic [AW-1:0]     den_ff   [QW];
   lci_div_side_type  side_ff  [QW];

   genvar j;
   for (j = 0; j < QW; j++) begin : g_step
      logic             p_valid;
      logic [AW-1:0]    p_rem;
      logic [QW-1:0]    p_low;
      logic [QW-1:0]    p_q;
      logic [AW-1:0]    p_den;
      lci_div_side_type p_side;
      logic [AW:0]      trial;
      logic [AW:0]      diff;
      logic             fits;

      // The integer part of the numerator seeds the remainder; the rest streams in.
      if (j == 0) begin : g_first
         assign p_valid = in_valid;
         assign p_rem   = AW'(num >> QSHIFT);
         assign p_low   = QW'(num) << FRAC_BITS;
         assign p_q     = '0;
         assign p_den   = den;
         assign p_side  = side_in;
      end else begin : g_next
         assign p_valid = valid_ff[j-1];
         assign p_rem   = rem_ff[j-1];
         assign p_low   = low_ff[j-1];
         assign p_q     = q_ff[j-1];
         assign p_den   = den_ff[j-1];
         assign p_side  = side_ff[j-1];
      end

      // Shift in the next numerator bit and subtract the divisor when it fits.
      always_comb begin
         trial = {p_rem, p_low[QW-1]};
         diff  = trial - {1'b0, p_den};
         fits  = trial >= {1'b0, p_den};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (advance) begin
            valid_ff[j] <= p_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j]  <= fits ? diff[AW-1:0] : trial[AW-1:0];
            low_ff[j]  <= p_low << 1;
            q_ff[j]    <= {p_q[QW-2:0], fits};
            den_ff[j]  <= p_den;
            side_ff[j] <= p_side;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign quot      = q_ff[QW-1];
   assign side_out  = side_ff[QW-1];

endmodule

// ----- rtl/core/line_cylinder_intersection_core.sv -----
// Top level of the line/cylinder crossing solver: products, discriminant, root, divide.
// Depends on lci_pkg, lci_ifs, lci_sqrt and lci_div.
//
//   Port      Dir  Carries                                   Transfer when
//   req_bus   in   origin_x, origin_y, dir_x, dir_y          valid && ready
//   rsp_bus   out  path_param, hit_status                    valid && ready
//   csr_bus   in   cylinder_radius                           valid && ready (ready held high)
//
// One item enters per cycle while responses are taken; a result passes through 91 register
// stages: six arithmetic stages, 50 square-root stages, two root-select stages, 32 divider
// stages and the output register. Every stage advances together whenever the output
// register is empty or being taken, so a stalled response holds the whole pipeline.
// Reset is synchronous and clears all valid bits and the radius register.
`timescale 1ns / 1ps

module line_cylinder_intersection_core (
   input  logic       clock,
   input  logic       reset,
   lci_req_if.sink    req_bus,
   lci_rsp_if.source  rsp_bus,
   lci_csr_if.sink    csr_bus
);
   import lci_pkg::*;

   logic advance;

   // Radius register.
   logic [RW-1:0] radius_ff;

   // Stage 1: raw products.
   logic                          s1_valid_ff;
   logic signed [2*CW-1:0]        s1_cc1_ff, s1_cc2_ff;
   logic signed [XW+CW-1:0]       s1_xc1_ff, s1_yc2_ff;
   logic signed [2*XW-1:0]        s1_xx_ff, s1_yy_ff;
   logic [2*RW-1:0]               s1_rr_ff;

   // Stage 2: sums.
   logic                          s2_valid_ff;
   logic [AW-1:0]                 s2_a_ff;
   logic signed [BW-1:0]          s2_b_ff;
   logic [P2W-1:0]                s2_p2_ff;
   logic [P2W-1:0]                s2_rr_ff;

   // Stage 3: magnitudes.
   logic                          s3_valid_ff;
   logic [AW-1:0]                 s3_a_ff;
   logic signed [BW-1:0]          s3_b_ff;
   logic [BMW-1:0]                s3_bmag_ff;
   logic [P2W-1:0]                s3_dmag_ff;
   logic                          s3_dneg_ff;
   logic [P2W:0]                  s3_diff;

   // Stage 4: partial products of b^2 and a*(p2 - r2).
   logic                          s4_valid_ff;
   logic [AW-1:0]                 s4_a_ff;
   logic signed [BW-1:0]          s4_b_ff;
   logic                          s4_dneg_ff;
   logic [63:0]                   s4_pb0_ff;
   logic [BMW-1:0]                s4_pb1_ff;
   logic [2*(BMW-32)-1:0]         s4_pb2_ff;
   logic [AW+31:0]                s4_pa0_ff, s4_pa1_ff;

   // Stage 5: assembled b^2 and a*c.
   logic                          s5_valid_ff;
   logic [AW-1:0]                 s5_a_ff;
   logic signed [BW-1:0]          s5_b_ff;
   logic                          s5_dneg_ff;
   logic [DW-1:0]                 s5_bb_ff, s5_ac_ff;

   // Stage 6: discriminant.
   logic                          s6_valid_ff;
   logic [DW-1:0]                 s6_d_ff;
   lci_sq_side_type               s6_side_ff;
   lci_sq_side_type               s6_side_in;

   // Square root results.
   logic                          sq_valid;
   logic [SQW-1:0]                sq_root;
   lci_sq_side_type               sq_side;

   // Stage 7: root selection.
   logic                          s7_valid_ff;
   logic [NW-1:0]                 s7_n_ff;
   logic [AW-1:0]                 s7_a_ff;
   logic [1:0]                    s7_status_ff;
   logic signed [NW:0]            s7_np, s7_nm;
   logic [NW-1:0]                 s7_n_in;
   logic [1:0]                    s7_status_in;

   // Stage 8: saturation check.
   logic                          s8_valid_ff;
   logic [NW-1:0]                 s8_n_ff;
   logic [AW-1:0]                 s8_a_ff;
   lci_div_side_type              s8_side_ff;

   // Divider results.
   logic                          dv_valid;
   logic [QW-1:0]                 dv_quot;
   lci_div_side_type              dv_side;

   // Output register.
   logic                          rsp_valid_ff;
   logic [TW-1:0]                 rsp_path_ff;
   logic [1:0]                    rsp_status_ff;

   // The pipeline moves as one whenever the output register can take a result.
   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   // Register writes are always taken.
   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
      end else if (csr_bus.valid) begin
         radius_ff <= csr_bus.cylinder_radius;
      end
   end

   // Valid bits for the arithmetic stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_bus.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= sq_valid;
         s8_valid_ff <= s7_valid_ff;
      end
   end

   // Stage 1: squares and cross products of the request fields and the radius.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cc1_ff <= (2*CW)'(req_bus.dir_x) * (2*CW)'(req_bus.dir_x);
         s1_cc2_ff <= (2*CW)'(req_bus.dir_y) * (2*CW)'(req_bus.dir_y);
         s1_xc1_ff <= (XW+CW)'(req_bus.origin_x) * (XW+CW)'(req_bus.dir_x);
         s1_yc2_ff <= (XW+CW)'(req_bus.origin_y) * (XW+CW)'(req_bus.dir_y);
         s1_xx_ff  <= (2*XW)'(req_bus.origin_x) * (2*XW)'(req_bus.origin_x);
         s1_yy_ff  <= (2*XW)'(req_bus.origin_y) * (2*XW)'(req_bus.origin_y);
         s1_rr_ff  <= (2*RW)'(radius_ff) * (2*RW)'(radius_ff);
      end
   end

   // Stage 2: a, b and the squared distance from the axis.
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_a_ff  <= AW'($unsigned(s1_cc1_ff)) + AW'($unsigned(s1_cc2_ff));
         s2_b_ff  <= BW'(s1_xc1_ff) + BW'(s1_yc2_ff);
         s2_p2_ff <= $unsigned(s1_xx_ff) + $unsigned(s1_yy_ff);
         s2_rr_ff <= P2W'(s1_rr_ff);
      end
   end

   // Stage 3: magnitudes of b and of p2 - r2.
   assign s3_diff = {1'b0, s2_p2_ff} - {1'b0, s2_rr_ff};
   always_ff @(posedge clock) begin
      if (advance) begin
         s3_a_ff    <= s2_a_ff;
         s3_b_ff    <= s2_b_ff;
         s3_bmag_ff <= s2_b_ff[BW-1] ? BMW'(-s2_b_ff) : BMW'(s2_b_ff);
         s3_dneg_ff <= s3_diff[P2W];
         s3_dmag_ff <= s3_diff[P2W] ? P2W'(-s3_diff) : s3_diff[P2W-1:0];
      end
   end

   // Stage 4: split the wide products into 32-bit pieces.
   always_ff @(posedge clock) begin
      if (advance) begin
         s4_a_ff    <= s3_a_ff;
         s4_b_ff    <= s3_b_ff;
         s4_dneg_ff <= s3_dneg_ff;
         s4_pb0_ff  <= 64'(s3_bmag_ff[31:0]) * 64'(s3_bmag_ff[31:0]);
         s4_pb1_ff  <= BMW'(s3_bmag_ff[31:0]) * BMW'(s3_bmag_ff[BMW-1:32]);
         s4_pb2_ff  <= (2*(BMW-32))'(s3_bmag_ff[BMW-1:32])
                       * (2*(BMW-32))'(s3_bmag_ff[BMW-1:32]);
         s4_pa0_ff  <= (AW+32)'(s3_a_ff) * (AW+32)'(s3_dmag_ff[31:0]);
         s4_pa1_ff  <= (AW+32)'(s3_a_ff) * (AW+32)'(s3_dmag_ff[P2W-1:32]);
      end
   end

   // Stage 5: assemble b^2 and a*|p2 - r2|.
   always_ff @(posedge clock) begin
      if (advance) begin
         s5_a_ff    <= s4_a_ff;
         s5_b_ff    <= s4_b_ff;
         s5_dneg_ff <= s4_dneg_ff;
         s5_bb_ff   <= DW'(s4_pb0_ff) + (DW'(s4_pb1_ff) << 33) + (DW'(s4_pb2_ff) << 64);
         s5_ac_ff   <= DW'(s4_pa0_ff) + (DW'(s4_pa1_ff) << 32);
      end
   end

   // Stage 6: discriminant and the early status flags.
   always_comb begin
      s6_side_in.a = s5_a_ff;
      s6_side_in.b = s5_b_ff;
      if (s5_a_ff == '0) begin
         s6_side_in.status = ST_ZERO_DIR;
      end else if (!s5_dneg_ff && (s5_ac_ff > s5_bb_ff)) begin
         s6_side_in.status = ST_NO_ROOT;
      end else begin
         s6_side_in.status = ST_LARGER;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_d_ff    <= s5_dneg_ff ? s5_bb_ff + s5_ac_ff : s5_bb_ff - s5_ac_ff;
         s6_side_ff <= s6_side_in;
      end
   end

   lci_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (s6_valid_ff),
      .radicand (s6_d_ff),
      .side_in  (s6_side_ff),
      .out_valid(sq_valid),
      .root     (sq_root),
      .side_out (sq_side)
   );

   // Stage 7: pick the larger root when it is non-negative, else the smaller one if it is, else no root.
   always_comb begin
      s7_np = -((NW+1)'(sq_side.b)) + $signed({3'b000, sq_root});
      s7_nm = -((NW+1)'(sq_side.b)) - $signed({3'b000, sq_root});
      s7_n_in      = '0;
      s7_status_in = sq_side.status;
      if (sq_side.status == ST_LARGER) begin
         if (!s7_np[NW]) begin
            s7_n_in = s7_np[NW-1:0];
         end else if (!s7_nm[NW]) begin
            s7_n_in      = s7_nm[NW-1:0];
            s7_status_in = ST_SMALLER;
         end else begin
            s7_status_in = ST_NO_ROOT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s7_n_ff      <= s7_n_in;
         s7_a_ff      <= sq_side.a;
         s7_status_ff <= s7_status_in;
      end
   end

   // Stage 8: the quotient saturates when its integer part exceeds the output range.
   always_ff @(posedge clock) begin
      if (advance) begin
         s8_n_ff           <= s7_n_ff;
         s8_a_ff           <= s7_a_ff;
         s8_side_ff.status <= s7_status_ff;
         s8_side_ff.sat    <= CMPW'(s7_n_ff) >= (CMPW'(s7_a_ff) << QSHIFT);
      end
   end

   lci_div u_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (s8_valid_ff),
      .num      (s8_n_ff),
      .den      (s8_a_ff),
      .side_in  (s8_side_ff),
      .out_valid(dv_valid),
      .quot     (dv_quot),
      .side_out (dv_side)
   );

   // Output register: zero for the flagged cases, all ones on saturation.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= dv_side.status;
         if (dv_side.status == ST_NO_ROOT || dv_side.status == ST_ZERO_DIR) begin
            rsp_path_ff <= '0;
         end else if (dv_side.sat) begin
            rsp_path_ff <= '1;
         end else begin
            rsp_path_ff <= dv_quot;
         end
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.path_param = rsp_path_ff;
   assign rsp_bus.hit_status = rsp_status_ff;

   // A zero direction is flagged before the square root.
   a_zero_dir_flag : assert property (@(posedge clock) disable iff (reset)
      (s6_valid_ff && s6_side_ff.a == '0) |-> s6_side_ff.status == ST_ZERO_DIR)
      else $error("zero direction not flagged at discriminant stage");

   // Flagged results never carry a path parameter.
   a_flag_zero_path : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_NO_ROOT || rsp_status_ff == ST_ZERO_DIR))
      |-> rsp_path_ff == '0)
      else $error("flagged result with nonzero path parameter");

   // A held pipeline keeps its root stage unchanged.
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (!advance && s7_valid_ff) |=> (s7_valid_ff && $stable(s7_n_ff)))
      else $error("root stage changed during a stall");

endmodule
